FILE: design/fhrp_pkg.sv
// Shared types and constants for the Firmata host receive parser.
`timescale 1ns / 1ps
package fhrp_pkg;
    localparam logic [2:0] KIND_DIGITAL = 3'd0;
    localparam logic [2:0] KIND_ANALOG  = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_SYSEX   = 3'd3;
    localparam logic [2:0] KIND_FW      = 3'd4;

    localparam logic [1:0] PEND_DIGITAL = 2'd0;
    localparam logic [1:0] PEND_ANALOG  = 2'd1;
    localparam logic [1:0] PEND_VERSION = 2'd2;

    localparam logic [7:0] CMD_DIGITAL   = 8'h90;
    localparam logic [7:0] CMD_ANALOG    = 8'hE0;
    localparam logic [7:0] CMD_VERSION   = 8'hF9;
    localparam logic [7:0] CMD_SYSEX     = 8'hF0;
    localparam logic [7:0] CMD_SYSEX_END = 8'hF7;
    localparam logic [7:0] SYSEX_FW      = 8'h79;
    localparam logic [7:0] SYSEX_STRING  = 8'h71;
    localparam logic [11:0] LAYOUT_THRESHOLD = 12'd23;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  pin;
        logic [13:0] value;
        logic [6:0]  minor;
        logic        last;
    } event_t;

    // work handed from the decoder to the pin scanner
    typedef struct packed {
        logic        is_port;
        logic        is_single;
        logic [4:0]  first_pin;
        logic [3:0]  count;
        logic [7:0]  bits;
        event_t      single;
    } job_t;
endpackage

FILE: design/fhrp_scan.sv
// Pin scanner: walks the pins of a port one at a time against the pin-value memory.
`timescale 1ns / 1ps
module fhrp_scan
    import fhrp_pkg::*;
#(
    parameter int NUM_PINS = 22
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  job_t                job,
    input  logic [NUM_PINS-1:0] input_pin_mask,
    output logic                ev_valid,
    input  logic                ev_ready,
    output event_t              ev
);
    logic [0:0] dval_mem [NUM_PINS];
    logic [NUM_PINS-1:0] seen_reg;
    logic        busy_reg;
    job_t        job_reg;
    logic [3:0]  idx_reg;
    logic        pend_reg;
    event_t      pend_ev_reg;
    logic        ev_valid_reg;
    event_t      ev_reg;
    logic        rd_ok_reg;
    logic [0:0]  rd_data_reg;

    logic [4:0]  pin_now;
    logic        in_range, done_after;
    logic        out_free;
    logic        step;
    logic        nb;
    logic        emit;

    assign out_free  = !ev_valid_reg || ev_ready;
    assign job_ready = !busy_reg && !pend_reg && out_free;
    assign pin_now   = job_reg.first_pin + 5'(idx_reg);
    assign in_range  = (pin_now < 5'(NUM_PINS));
    assign nb        = job_reg.bits[3'(job_reg.first_pin[2:0] + 3'(idx_reg))];
    assign step      = busy_reg && job_reg.is_port && rd_ok_reg && out_free;
    assign done_after = (idx_reg + 4'd1 >= job_reg.count);

    always_comb begin
        emit = 1'b0;
        if (in_range && input_pin_mask[pin_now]) begin
            emit = !seen_reg[pin_now] || (rd_data_reg != nb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            seen_reg     <= '0;
            rd_ok_reg    <= 1'b0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
        end else begin
            if (ev_valid_reg && ev_ready) begin
                ev_valid_reg <= 1'b0;
            end
            rd_ok_reg <= 1'b0;
            if (job_valid && job_ready) begin
                job_reg <= job;
                idx_reg <= '0;
                pend_reg <= 1'b0;
                if (job.is_single) begin
                    ev_reg       <= job.single;
                    ev_valid_reg <= 1'b1;
                end else if (job.is_port && job.count != 4'd0) begin
                    busy_reg <= 1'b1;
                end
            end else if (step) begin
                // hold one event back so the final one carries last
                if (emit) begin
                    if (pend_reg) begin
                        ev_reg       <= pend_ev_reg;
                        ev_valid_reg <= 1'b1;
                    end
                    pend_reg    <= 1'b1;
                    pend_ev_reg <= '{kind: KIND_DIGITAL, pin: pin_now,
                                     value: 14'(nb), minor: 7'd0, last: 1'b0};
                end
                if (in_range && input_pin_mask[pin_now]) begin
                    seen_reg[pin_now] <= 1'b1;
                end
                idx_reg <= idx_reg + 4'd1;
                if (done_after) begin
                    busy_reg <= 1'b0;
                end
            end else if (busy_reg && !job_reg.is_port) begin
                busy_reg <= 1'b0;
            end
            if (busy_reg && job_reg.is_port && !rd_ok_reg && !step) begin
                rd_ok_reg <= 1'b1;
            end
            if (!busy_reg && pend_reg && out_free && !(job_valid && job_ready)) begin
                ev_reg       <= '{kind: pend_ev_reg.kind, pin: pend_ev_reg.pin,
                                  value: pend_ev_reg.value, minor: pend_ev_reg.minor,
                                  last: 1'b1};
                ev_valid_reg <= 1'b1;
                pend_reg     <= 1'b0;
            end
        end
    end

    // single-port pin-value memory: registered read ahead of the step, write on a step for a masked in-range pin
    always_ff @(posedge aclk) begin
        if (step && in_range && input_pin_mask[pin_now]) begin
            dval_mem[pin_now] <= nb;
        end
        if (in_range) begin
            rd_data_reg <= dval_mem[pin_now];
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !job_ready) else $error("job accepted while scanning");
    a_step_needs_read: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> rd_ok_reg) else $error("step without memory data");
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && job_reg.is_port |-> idx_reg < job_reg.count)
        else $error("scan index past port");
endmodule

FILE: design/firmata_host_receive_parser_core.sv
// Top level: byte decoder with analog value memory, feeding the pin scanner.
// Path: a version, sysex or firmware result goes straight to the scanner's output register,
// an analog change first through the compare stage, and a digital port message through the pin walk.
// Throughput: one byte a cycle while no analog compare is pending; a byte with results waits while
// a result is held or a port is scanned. A port scan covers up to 8 pins in a read-then-write walk
// of the pin-value memory.
// Reset: synchronous active-low aresetn clears all control state and seen flags.
`timescale 1ns / 1ps
module firmata_host_receive_parser_core
    import fhrp_pkg::*;
#(
    parameter int NUM_PINS   = 22,
    parameter int NUM_ANALOG = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [21:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_event_kind,
    output logic [4:0]          m_pin,
    output logic [13:0]         m_value,
    output logic [6:0]          m_minor_value,
    output logic                m_last
);
    localparam int AW = (NUM_ANALOG > 1) ? $clog2(NUM_ANALOG) : 1;

    logic [21:0] mask_reg;
    logic [1:0]  wait_reg;
    logic        sysex_reg;
    logic [1:0]  pend_reg;
    logic [3:0]  chan_reg;
    logic [6:0]  first_reg;
    logic        layout_reg;
    logic [7:0]  sx_cnt_reg, sx_cmd_reg, fw_maj_reg, fw_min_reg;

    logic [13:0] an_mem [NUM_ANALOG];
    logic [NUM_ANALOG-1:0] an_seen_reg;

    // stage two: analog compare after memory read
    logic        an_v_reg;
    logic [3:0]  an_ch_reg;
    logic [13:0] an_new_reg, an_rd_reg;
    logic        an_seen_s2_reg;

    logic   job_valid, job_ready;
    job_t   job;
    event_t ev;
    logic   s_fire;
    logic [7:0] b;
    logic [13:0] v14;
    logic [11:0] fw_sum;

    assign s_ready = !an_v_reg && (!job_valid || job_ready);
    assign s_fire  = s_valid && s_ready;
    assign b       = s_rx_byte;
    assign v14     = {b[6:0], first_reg};
    assign fw_sum  = 12'(fw_maj_reg) * 12'd10 + 12'(fw_min_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cfg_we) begin
            mask_reg <= cfg_wdata;
        end
    end

    // decode
    always_comb begin
        job       = '0;
        job_valid = 1'b0;
        if (an_v_reg) begin
            job_valid = an_seen_s2_reg && (an_rd_reg != an_new_reg);
            job.is_single = 1'b1;
            job.single = '{kind: KIND_ANALOG, pin: 5'(an_ch_reg), value: an_new_reg,
                           minor: 7'd0, last: 1'b1};
        end else if (s_valid) begin
            if (wait_reg != 2'd0 && !b[7]) begin
                if (wait_reg == 2'd1 && pend_reg == PEND_DIGITAL) begin
                    job_valid     = 1'b1;
                    job.is_port   = 1'b1;
                    job.bits      = v14[7:0];
                    case (chan_reg)
                        4'd0: begin job.first_pin = 5'd2; job.count = 4'd6; end
                        4'd1: begin job.first_pin = 5'd8;
                                    job.count = layout_reg ? 4'd8 : 4'd6; end
                        4'd2: begin job.first_pin = 5'd16;
                                    job.count = layout_reg ? 4'd4 : 4'd6; end
                        default: begin job.is_port = 1'b0; job_valid = 1'b0; end
                    endcase
                end else if (wait_reg == 2'd1 && pend_reg == PEND_VERSION) begin
                    job_valid = 1'b1;
                    job.is_single = 1'b1;
                    job.single = '{kind: KIND_VERSION, pin: 5'd0,
                                   value: 14'(first_reg), minor: b[6:0], last: 1'b1};
                end
            end else if (sysex_reg) begin
                if (b == CMD_SYSEX_END) begin
                    if (sx_cnt_reg != 8'd0 && sx_cmd_reg == SYSEX_FW) begin
                        job_valid = 1'b1;
                        job.is_single = 1'b1;
                        job.single = '{kind: KIND_FW, pin: 5'd0, value: 14'(fw_maj_reg),
                                       minor: fw_min_reg[6:0], last: 1'b1};
                    end else if (!(sx_cnt_reg != 8'd0 && sx_cmd_reg == SYSEX_STRING)) begin
                        job_valid = 1'b1;
                        job.is_single = 1'b1;
                        job.single = '{kind: KIND_SYSEX, pin: 5'd0, value: 14'd0,
                                       minor: 7'd0, last: 1'b1};
                    end
                end else begin
                    if (!(sx_cnt_reg == 8'd0 ? (b == SYSEX_FW || b == SYSEX_STRING)
                          : (sx_cmd_reg == SYSEX_FW || sx_cmd_reg == SYSEX_STRING))) begin
                        job_valid = 1'b1;
                        job.is_single = 1'b1;
                        job.single = '{kind: KIND_SYSEX, pin: 5'd0, value: 14'(b),
                                       minor: 7'd0, last: 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg <= '0; sysex_reg <= 1'b0; pend_reg <= PEND_DIGITAL;
            chan_reg <= '0; first_reg <= '0; layout_reg <= 1'b0;
            sx_cnt_reg <= '0; sx_cmd_reg <= '0; fw_maj_reg <= '0; fw_min_reg <= '0;
            an_seen_reg <= '0; an_v_reg <= 1'b0;
        end else begin
            if (an_v_reg && (!job_valid || job_ready)) begin
                an_v_reg <= 1'b0;
            end
            if (s_fire) begin
                if (wait_reg != 2'd0 && !b[7]) begin
                    wait_reg <= wait_reg - 2'd1;
                    if (wait_reg == 2'd2) begin
                        first_reg <= b[6:0];
                    end else if (pend_reg == PEND_ANALOG &&
                                 32'(chan_reg) < NUM_ANALOG) begin
                        an_v_reg       <= 1'b1;
                        an_ch_reg      <= chan_reg;
                        an_new_reg     <= v14;
                        an_seen_s2_reg <= an_seen_reg[AW'(chan_reg)];
                        an_seen_reg[AW'(chan_reg)] <= 1'b1;
                    end
                end else if (sysex_reg) begin
                    if (b == CMD_SYSEX_END) begin
                        sysex_reg <= 1'b0;
                        if (sx_cnt_reg != 8'd0 && sx_cmd_reg == SYSEX_FW) begin
                            layout_reg <= (fw_sum >= LAYOUT_THRESHOLD);
                        end
                    end else begin
                        if (sx_cnt_reg == 8'd0) begin
                            sx_cmd_reg <= b;
                        end else if (sx_cmd_reg == SYSEX_FW) begin
                            if (sx_cnt_reg == 8'd1) fw_maj_reg <= b;
                            if (sx_cnt_reg == 8'd2) fw_min_reg <= b;
                        end
                        if (sx_cnt_reg != 8'hFF) sx_cnt_reg <= sx_cnt_reg + 8'd1;
                    end
                end else begin
                    if (b < CMD_SYSEX) chan_reg <= b[3:0];
                    if ((b < CMD_SYSEX ? {b[7:4], 4'h0} : b) == CMD_DIGITAL) begin
                        wait_reg <= 2'd2; pend_reg <= PEND_DIGITAL;
                    end else if ((b < CMD_SYSEX ? {b[7:4], 4'h0} : b) == CMD_ANALOG) begin
                        wait_reg <= 2'd2; pend_reg <= PEND_ANALOG;
                    end else if (b == CMD_VERSION) begin
                        wait_reg <= 2'd2; pend_reg <= PEND_VERSION;
                    end else if (b == CMD_SYSEX) begin
                        wait_reg <= 2'd0; sysex_reg <= 1'b1;
                        sx_cnt_reg <= '0; sx_cmd_reg <= '0;
                    end
                end
            end
        end
    end

    // analog value memory: read old value, write new one in the same cycle
    always_ff @(posedge aclk) begin
        if (s_fire && wait_reg == 2'd1 && !b[7] && pend_reg == PEND_ANALOG &&
            32'(chan_reg) < NUM_ANALOG) begin
            an_rd_reg <= an_mem[AW'(chan_reg)];
            an_mem[AW'(chan_reg)] <= v14;
        end
    end

    fhrp_scan #(.NUM_PINS(NUM_PINS)) u_scan (
        .aclk, .aresetn,
        .job_valid (job_valid && (an_v_reg || s_valid)),
        .job_ready,
        .job,
        .input_pin_mask (mask_reg[NUM_PINS-1:0]),
        .ev_valid (m_valid),
        .ev_ready (m_ready),
        .ev
    );

    assign m_event_kind  = ev.kind;
    assign m_pin         = ev.pin;
    assign m_value       = ev.value;
    assign m_minor_value = ev.minor;
    assign m_last        = ev.last;

    a_an_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        an_v_reg |-> !s_ready) else $error("byte taken during analog compare");
    a_wait_sysex: assert property (@(posedge aclk) disable iff (!aresetn)
        sysex_reg && $past(s_fire) && $past(b) == CMD_SYSEX |-> wait_reg == 2'd0)
        else $error("sysex with pending data");
    a_an_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        an_v_reg |-> 32'(an_ch_reg) < NUM_ANALOG) else $error("analog channel out of range");
endmodule

FILE: dv/firmata_host_receive_parser_core_tb.sv
// Testbench for the Firmata host receive parser: byte stream in, decoded events checked.
`timescale 1ns / 1ps
module firmata_host_receive_parser_core_tb;
    import fhrp_pkg::*;

    localparam int NPINS = 22;
    localparam int NANA = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [21:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_kind;
    logic [4:0]  m_pin;
    logic [13:0] m_value;
    logic [6:0]  m_minor_value;
    logic        m_last;

    firmata_host_receive_parser_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_kind(m_event_kind),
        .m_pin(m_pin), .m_value(m_value), .m_minor_value(m_minor_value),
        .m_last(m_last)
    );

    always #5 aclk = ~aclk;

    // decoder state mirror
    logic [21:0] pin_mask;
    logic [1:0]  bytes_left;
    logic        sysex_open;
    logic [1:0]  pend_kind;
    logic [3:0]  chan;
    logic [6:0]  lsb_byte;
    logic [13:0] ana_val [NANA];
    logic        ana_known [NANA];
    logic        dig_val [NPINS];
    logic        dig_known [NPINS];
    logic        layout_new;
    logic [7:0]  sx_len;
    logic [7:0]  sx_id;
    logic [7:0]  fw_maj;
    logic [7:0]  fw_min;

    event_t      pending_events[$];
    logic [7:0]  byte_queue[$];
    int          errors = 0;
    int          cycles = 0;
    int          taken_count = 0;
    int          driven_count = 0;
    int          s_idle_pct = 27;
    int          m_idle_pct = 49;
    bit          hold_off = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void add_byte(input logic [7:0] v);
        byte_queue.insert(byte_queue.size(), v);
    endfunction

    function automatic void post_events(input event_t evs[$]);
        foreach (evs[i]) pending_events.insert(pending_events.size(), evs[i]);
    endfunction

    function automatic void push_event(inout event_t evs[$], input logic [2:0] k,
                                       input logic [4:0] p, input logic [13:0] v,
                                       input logic [6:0] mn, input logic l);
        event_t e;
        e.kind = k; e.pin = p; e.value = v; e.minor = mn; e.last = l;
        evs.insert(evs.size(), e);
    endfunction

    function automatic void decode_port(inout event_t evs[$], input logic [3:0] port,
                                        input logic [7:0] v8);
        int lo, cnt, base;
        logic nb;
        if (port == 0) begin
            lo = 2; cnt = 8; base = 0;
        end else if (port == 1) begin
            lo = 0; cnt = layout_new ? 8 : 6; base = 8;
        end else if (port == 2) begin
            lo = 0; cnt = layout_new ? 4 : 6; base = 16;
        end else begin
            return;
        end
        for (int b = lo; b < cnt; b++) begin
            if (base + b >= NPINS || !pin_mask[base + b]) continue;
            nb = v8[b];
            if (!dig_known[base + b] || dig_val[base + b] != nb)
                push_event(evs, KIND_DIGITAL, 5'(base + b), {13'd0, nb}, 7'd0, 1'b0);
            dig_val[base + b] = nb;
            dig_known[base + b] = 1'b1;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        event_t evs[$];
        logic [13:0] v14;
        logic [7:0] cmd;
        if (bytes_left > 2'd0 && b < 8'd128) begin
            bytes_left--;
            if (bytes_left != 2'd0) begin
                lsb_byte = b[6:0];
            end else begin
                v14 = {b[6:0], lsb_byte};
                if (pend_kind == PEND_DIGITAL) begin
                    decode_port(evs, chan, v14[7:0]);
                end else if (pend_kind == PEND_ANALOG) begin
                    if (chan < NANA) begin
                        if (ana_known[chan] && ana_val[chan] != v14)
                            push_event(evs, KIND_ANALOG, {1'b0, chan}, v14, 7'd0, 1'b0);
                        ana_val[chan] = v14;
                        ana_known[chan] = 1'b1;
                    end
                end else begin
                    push_event(evs, KIND_VERSION, 5'd0, {7'd0, lsb_byte}, b[6:0], 1'b0);
                end
            end
        end else if (sysex_open) begin
            if (b == CMD_SYSEX_END) begin
                sysex_open = 1'b0;
                if (sx_len >= 8'd1 && sx_id == SYSEX_FW) begin
                    layout_new = (12'(fw_maj) * 12'd10 + 12'(fw_min)) >= LAYOUT_THRESHOLD;
                    push_event(evs, KIND_FW, 5'd0, {6'd0, fw_maj}, fw_min[6:0], 1'b0);
                end else if (!(sx_len >= 8'd1 && sx_id == SYSEX_STRING)) begin
                    push_event(evs, KIND_SYSEX, 5'd0, 14'd0, 7'd0, 1'b1);
                    post_events(evs);
                    return;
                end
            end else begin
                if (sx_len == 8'd0) sx_id = b;
                if (sx_id == SYSEX_FW) begin
                    if (sx_len == 8'd1) fw_maj = b;
                    else if (sx_len == 8'd2) fw_min = b;
                end else if (sx_id != SYSEX_STRING) begin
                    push_event(evs, KIND_SYSEX, 5'd0, {6'd0, b}, 7'd0, 1'b0);
                end
                if (sx_len < 8'd255) sx_len++;
                post_events(evs);
                return;
            end
        end else begin
            if (b < 8'hF0) begin
                cmd = b & 8'hF0;
                chan = b[3:0];
            end else begin
                cmd = b;
            end
            if (cmd == CMD_DIGITAL) begin
                bytes_left = 2'd2; pend_kind = PEND_DIGITAL;
            end else if (cmd == CMD_ANALOG) begin
                bytes_left = 2'd2; pend_kind = PEND_ANALOG;
            end else if (cmd == CMD_VERSION) begin
                bytes_left = 2'd2; pend_kind = PEND_VERSION;
            end else if (cmd == CMD_SYSEX) begin
                bytes_left = 2'd0; sysex_open = 1'b1; sx_len = 8'd0; sx_id = 8'd0;
            end
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        post_events(evs);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && taken_count == driven_count) begin
                // hold
            end else begin
                driven_count = taken_count;
                if (byte_queue.size() > 0 && !hold_off
                    && $urandom_range(99) >= s_idle_pct) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= byte_queue[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        event_t exp_ev;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            decode_byte(s_rx_byte);
            void'(byte_queue.pop_front());
            taken_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d pin %0d value %0d",
                                          m_event_kind, m_pin, m_value));
            end else begin
                exp_ev = pending_events.pop_front();
                if (m_event_kind !== exp_ev.kind || m_pin !== exp_ev.pin ||
                    m_value !== exp_ev.value || m_minor_value !== exp_ev.minor ||
                    m_last !== exp_ev.last)
                    report_mismatch($sformatf(
                        "got %0d/%0d/%0d/%0d/%0d expected %0d/%0d/%0d/%0d/%0d",
                        m_event_kind, m_pin, m_value, m_minor_value, m_last,
                        exp_ev.kind, exp_ev.pin, exp_ev.value, exp_ev.minor,
                        exp_ev.last));
            end
        end
    end

    task automatic wait_drained();
        while (byte_queue.size() > 0 || s_valid || pending_events.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [21:0] m);
        wait_drained();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 1'b0;
        pin_mask = m;
    endtask

    task automatic queue_random_message();
        int sel;
        int n;
        sel = $urandom_range(99);
        if (sel < 35) begin
            add_byte(CMD_DIGITAL | 8'($urandom_range(3)));
            add_byte(8'($urandom_range(127)));
            add_byte(8'($urandom_range(127)));
        end else if (sel < 55) begin
            add_byte(CMD_ANALOG | 8'($urandom_range(15)));
            add_byte(8'($urandom_range(127)));
            add_byte(($urandom_range(3) == 0) ? 8'($urandom_range(127))
                                              : 8'($urandom_range(1)));
        end else if (sel < 62) begin
            add_byte(CMD_VERSION);
            add_byte(8'($urandom_range(127)));
            add_byte(8'($urandom_range(127)));
        end else if (sel < 70) begin
            add_byte(CMD_SYSEX);
            add_byte(SYSEX_FW);
            n = $urandom_range(3);
            repeat (n) add_byte(8'($urandom_range(4)));
            add_byte(CMD_SYSEX_END);
        end else if (sel < 82) begin
            add_byte(CMD_SYSEX);
            n = $urandom_range(5);
            if ($urandom_range(4) == 0) add_byte(SYSEX_STRING);
            repeat (n) add_byte(8'($urandom_range(255)));
            if (byte_queue[byte_queue.size() - 1] != CMD_SYSEX_END)
                add_byte(CMD_SYSEX_END);
        end else begin
            add_byte(8'($urandom_range(255)));
        end
    endtask

    initial begin
        bytes_left = '0; sysex_open = 1'b0; pend_kind = PEND_DIGITAL; chan = '0;
        lsb_byte = '0; layout_new = 1'b0; sx_len = '0; sx_id = '0; fw_maj = '0;
        fw_min = '0; pin_mask = '0;
        for (int i = 0; i < NANA; i++) begin
            ana_known[i] = 1'b0; ana_val[i] = '0;
        end
        for (int i = 0; i < NPINS; i++) begin
            dig_known[i] = 1'b0; dig_val[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_mask(22'h3FFFFF);
        byte_queue = '{8'h90, 8'h7F, 8'h01, 8'h91, 8'h2A, 8'h01, 8'h92, 8'h15, 8'h00,
                       8'hE3, 8'h7F, 8'h7F, 8'hE3, 8'h00, 8'h00, 8'hEF, 8'h01, 8'h02,
                       8'hF9, 8'h02, 8'h05, 8'hF7, 8'h93, 8'h05, 8'h55};
        write_mask(22'h000000);
        byte_queue = '{8'h90, 8'h00, 8'h00, 8'hF0, 8'h79, 8'h02, 8'h05, 8'hF7,
                       8'hF0, 8'hF7, 8'hF0, 8'h10, 8'hFF, 8'h80, 8'hF7,
                       8'hF0, 8'h71, 8'h41, 8'hF7, 8'hF9, 8'h01, 8'hE1, 8'h03, 8'h00};
        write_mask(22'h2AAAAA);
        hold_off = 1'b1;
        for (int i = 0; i < 25; i++) queue_random_message();
        hold_off = 1'b0;
        while (byte_queue.size() > 30) @(posedge aclk);
        hold_off = 1'b1;
        while (s_valid || pending_events.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        hold_off = 1'b0;
        for (int i = 0; i < 15; i++) queue_random_message();

        write_mask(22'($urandom));
        s_idle_pct = 49; m_idle_pct = 27;
        for (int i = 0; i < 20; i++) queue_random_message();
        write_mask(22'h3FFFFF);
        s_idle_pct = 0; m_idle_pct = 0;
        for (int i = 0; i < 10; i++) queue_random_message();
        write_mask(22'h155555);
        for (int i = 0; i < 5; i++) queue_random_message();
        wait_drained();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
